### hw/rtl/clog_pkg.sv
// Shared types, constants and helpers of the circular trace log.
`default_nettype none

package clog_pkg;

    localparam int CNT_W         = 5;
    localparam int WORD_W        = 32;
    localparam int DEF_LOG_DEPTH = 16;
    localparam int DEF_CAP       = 16;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [1:0] ST_ENTRY       = 2'd0;
    localparam logic [1:0] ST_OVER_CAP    = 2'd1;
    localparam logic [1:0] ST_OVER_STORED = 2'd2;
    localparam logic [1:0] ST_ZERO        = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [WORD_W-1:0] message_word;
        logic [WORD_W-1:0] arrival_time;
        logic [CNT_W-1:0]  request_count;
    } clog_cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] entry_message;
        logic [WORD_W-1:0] entry_time;
        logic [1:0]        status;
        logic              last;
    } clog_rsp_t;

    typedef struct packed {
        logic [CNT_W-1:0] capacity_in_use;
    } clog_cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] message;
        logic [WORD_W-1:0] stamp;
    } clog_entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } clog_mem_ctl_t;

    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] v, input int depth);
        logic [CNT_W-1:0] c;
        c = v;
        if (v == '0)
        begin
            c = CNT_W'(1);
        end
        else if (int'(v) > depth)
        begin
            c = CNT_W'(depth);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/clog_if.sv
// Valid/ready channel interfaces for command, response and configuration.
`default_nettype none

interface clog_cmd_if import clog_pkg::*; ();
    logic      valid;
    logic      ready;
    clog_cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface clog_rsp_if import clog_pkg::*; ();
    logic      valid;
    logic      ready;
    clog_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface clog_cfg_if import clog_pkg::*; ();
    logic      valid;
    logic      ready;
    clog_cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/clog_store.sv
// Entry memory: one write port, one read port with registered read data.
`default_nettype none

module clog_store import clog_pkg::*; #(
    parameter int LOG_DEPTH = DEF_LOG_DEPTH
) (
    input  wire logic                         clk,
    input  wire clog_mem_ctl_t                ctl,
    input  wire logic [$clog2(LOG_DEPTH)-1:0] wr_addr,
    input  wire clog_entry_t                  wr_data,
    input  wire logic [$clog2(LOG_DEPTH)-1:0] rd_addr,
    output clog_entry_t                       rd_data
);

    clog_entry_t mem [LOG_DEPTH];
    clog_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/clog_ctrl.sv
// Log sequencer: capacity register, write slot, fill count and newest-first readout.
`default_nettype none

module clog_ctrl import clog_pkg::*; #(
    parameter int LOG_DEPTH = DEF_LOG_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    clog_cmd_if.sink                           cmd,
    clog_rsp_if.source                         rsp,
    clog_cfg_if.sink                           cfg,
    output clog_mem_ctl_t                      mem_ctl,
    output logic [$clog2(LOG_DEPTH)-1:0]       wr_addr,
    output clog_entry_t                        wr_data,
    output logic [$clog2(LOG_DEPTH)-1:0]       rd_addr,
    input  wire clog_entry_t                   rd_data
);

    localparam int AW = $clog2(LOG_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic [CNT_W-1:0] cap_reg,    cap_next;
    logic [AW-1:0]    wslot_reg,  wslot_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             state_reg,  state_next;
    logic [AW-1:0]    rptr_reg,   rptr_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             ovalid_reg, ovalid_next;
    logic [1:0]       status_reg, status_next;
    logic             last_reg,   last_next;

    logic             out_free;
    logic             cmd_acc;
    logic             cfg_acc;
    logic [CNT_W-1:0] k;
    logic [AW-1:0]    cap_m1;
    logic [AW-1:0]    newest;
    logic [AW-1:0]    newest_m1;
    logic [AW-1:0]    rptr_m1;
    logic             start_read;
    logic             step_read;

    assign out_free  = !ovalid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign cfg.ready = 1'b1;
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign k         = cmd.data.request_count;

    assign cap_m1    = AW'(cap_reg - CNT_W'(1));
    assign newest    = (wslot_reg == '0) ? cap_m1 : wslot_reg - AW'(1);
    assign newest_m1 = (newest == '0) ? cap_m1 : newest - AW'(1);
    assign rptr_m1   = (rptr_reg == '0) ? cap_m1 : rptr_reg - AW'(1);

    assign start_read = cmd_acc && (cmd.data.opcode == OP_READ) && (k != '0)
                        && (k <= cap_reg) && (k <= count_reg);
    assign step_read  = (state_reg == S_READ) && out_free;

    assign mem_ctl.wr_en = cmd_acc && (cmd.data.opcode == OP_APPEND);
    assign mem_ctl.rd_en = start_read || step_read;
    assign wr_addr       = wslot_reg;
    assign wr_data       = '{message: cmd.data.message_word, stamp: cmd.data.arrival_time};
    assign rd_addr       = (state_reg == S_READ) ? rptr_reg : newest;

    always_comb
    begin
        cap_next    = cap_reg;
        wslot_next  = wslot_reg;
        count_next  = count_reg;
        state_next  = state_reg;
        rptr_next   = rptr_reg;
        remain_next = remain_reg;
        ovalid_next = ovalid_reg;
        status_next = status_reg;
        last_next   = last_reg;

        if (rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cfg_acc)
        begin
            cap_next   = clamp_cap(cfg.data.capacity_in_use, LOG_DEPTH);
            wslot_next = '0;
            count_next = '0;
        end
        else if (cmd_acc && (cmd.data.opcode == OP_APPEND))
        begin
            wslot_next = (wslot_reg == cap_m1) ? '0 : wslot_reg + AW'(1);
            if (count_reg < cap_reg)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (cmd_acc && (cmd.data.opcode == OP_READ))
        begin
            ovalid_next = 1'b1;
            last_next   = 1'b1;
            priority if (k == '0)
            begin
                status_next = ST_ZERO;
            end
            else if (k > cap_reg)
            begin
                status_next = ST_OVER_CAP;
            end
            else if (k > count_reg)
            begin
                status_next = ST_OVER_STORED;
            end
            else
            begin
                status_next = ST_ENTRY;
                last_next   = (k == CNT_W'(1));
                rptr_next   = newest_m1;
                remain_next = k - CNT_W'(1);
                if (k != CNT_W'(1))
                begin
                    state_next = S_READ;
                end
            end
        end

        if (step_read)
        begin
            ovalid_next = 1'b1;
            status_next = ST_ENTRY;
            last_next   = (remain_reg == CNT_W'(1));
            rptr_next   = rptr_m1;
            remain_next = remain_reg - CNT_W'(1);
            if (remain_reg == CNT_W'(1))
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= clamp_cap(CNT_W'(DEF_CAP), LOG_DEPTH);
            wslot_reg  <= '0;
            count_reg  <= '0;
            state_reg  <= S_IDLE;
            remain_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cap_reg    <= cap_next;
            wslot_reg  <= wslot_next;
            count_reg  <= count_next;
            state_reg  <= state_next;
            remain_reg <= remain_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rptr_reg   <= rptr_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign rsp.valid              = ovalid_reg;
    assign rsp.data.entry_message = (status_reg == ST_ENTRY) ? rd_data.message : '0;
    assign rsp.data.entry_time    = (status_reg == ST_ENTRY) ? rd_data.stamp : '0;
    assign rsp.data.status        = status_reg;
    assign rsp.data.last          = last_reg;

endmodule

`default_nettype wire

### hw/rtl/circular_log_with_tail_readout_core.sv
// Circular trace log with newest-first tail readout, top level.
//
// Channels: cmd takes appends (message word plus timestamp) and tail reads;
// rsp returns one transaction per read entry, newest first, last marking the
// final one, or a single status transaction for a read that cannot be served;
// cfg writes the capacity in use, which also empties the log.
// An append gives no response. A tail read of K entries issues one entry
// memory read per cycle while rsp is not stalled; each entry appears on rsp
// in the cycle after its read. The single read port of the entry memory
// sets the readout rate.
// The memory read data register doubles as the response register, so a
// new command is taken in the cycle the pending response is taken.
// Reset empties the log and sets capacity to 16 (or the depth, if smaller);
// the entry memory itself is not cleared.
// When the receiver stalls rsp, the response holds and readout pauses; cmd
// is not ready while a read is still being emitted.
`default_nettype none

module circular_log_with_tail_readout_core import clog_pkg::*; #(
    parameter int LOG_DEPTH = DEF_LOG_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    clog_cmd_if.sink   cmd,
    clog_rsp_if.source rsp,
    clog_cfg_if.sink   cfg
);

    localparam int AW = $clog2(LOG_DEPTH);

    clog_mem_ctl_t mem_ctl;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    clog_entry_t   wr_data;
    clog_entry_t   rd_data;

    clog_ctrl #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_clog_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .cfg     (cfg),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    clog_store #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_clog_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

### hw/rtl/clog_checker.sv
// Port-level assertions for the circular trace log, bound to the top level.
`default_nettype none

module clog_checker import clog_pkg::*; (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cmd_valid,
    input wire logic      cmd_ready,
    input wire logic      cmd_opcode,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire clog_rsp_t rsp_data
);

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != ST_ENTRY) |-> rsp_data.last)
        else $error("status response without last");

    a_status_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != ST_ENTRY)
        |-> (rsp_data.entry_message == '0) && (rsp_data.entry_time == '0))
        else $error("status response with nonzero payload");

    a_busy_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.last |-> !cmd_ready)
        else $error("command taken while a read is still being emitted");

    a_append_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_opcode == OP_APPEND) && !rsp_valid |=> !rsp_valid)
        else $error("append produced a response");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

endmodule

bind circular_log_with_tail_readout_core clog_checker u_clog_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_opcode (cmd.data.opcode),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_data   (rsp.data)
);

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the circular trace log with newest-first tail readout.
`timescale 1ns / 1ps

module testbench;
    import clog_pkg::*;

    localparam int LOG_SLOTS   = DEF_LOG_DEPTH;
    localparam int DRAIN_WAIT  = 6;
    localparam int REPORT_MAX  = 40;

    logic clk;
    logic rst_n;

    clog_cmd_if cmd_ch ();
    clog_rsp_if rsp_ch ();
    clog_cfg_if cfg_ch ();

    circular_log_with_tail_readout_core #(
        .LOG_DEPTH(LOG_SLOTS)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch.sink),
        .rsp  (rsp_ch.source),
        .cfg  (cfg_ch.sink)
    );

    logic [WORD_W-1:0] log_msg  [LOG_SLOTS];
    logic [WORD_W-1:0] log_time [LOG_SLOTS];
    int                wr_slot;
    int                fill_count;
    int                cap_now;
    clog_rsp_t         pending_entries_q[$];

    int  error_count;
    int  n_append;
    int  n_read;
    int  n_entry_rsp;
    int  n_status_rsp;
    int  n_cfg;
    bit  steady;
    int  hold_rsp_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout: %0d responses still outstanding", pending_entries_q.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic int capacity_from_raw(input logic [CNT_W-1:0] raw);
        if (raw == '0)
        begin
            return 1;
        end
        if (int'(raw) > LOG_SLOTS)
        begin
            return LOG_SLOTS;
        end
        return int'(raw);
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return '0;
        end
        if (r < 10)
        begin
            return '1;
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < REPORT_MAX)
        begin
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    task automatic queue_expected(input clog_rsp_t r);
        pending_entries_q = {pending_entries_q, r};
    endtask

    task automatic predict_tail_readout(input clog_cmd_t c);
        clog_rsp_t r;
        int        k;
        int        slot;
        if (c.opcode == OP_APPEND)
        begin
            log_msg[wr_slot]  = c.message_word;
            log_time[wr_slot] = c.arrival_time;
            wr_slot = (wr_slot + 1) % cap_now;
            if (fill_count < cap_now)
            begin
                fill_count++;
            end
            n_append++;
            return;
        end
        n_read++;
        k = int'(c.request_count);
        r = '0;
        r.last = 1'b1;
        if (k == 0)
        begin
            r.status = ST_ZERO;
            queue_expected(r);
        end
        else if (k > cap_now)
        begin
            r.status = ST_OVER_CAP;
            queue_expected(r);
        end
        else if (k > fill_count)
        begin
            r.status = ST_OVER_STORED;
            queue_expected(r);
        end
        else
        begin
            for (int i = 1; i <= k; i++)
            begin
                slot = (wr_slot + cap_now - i) % cap_now;
                r.entry_message = log_msg[slot];
                r.entry_time    = log_time[slot];
                r.status        = ST_ENTRY;
                r.last          = (i == k);
                queue_expected(r);
            end
        end
    endtask

    task automatic send_cmd(input logic op, input logic [WORD_W-1:0] msg,
                            input logic [WORD_W-1:0] tim, input logic [CNT_W-1:0] k);
        clog_cmd_t c;
        int        gap;
        c.opcode        = op;
        c.message_word  = msg;
        c.arrival_time  = tim;
        c.request_count = k;
        @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
        predict_tail_readout(c);
        gap = rand_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic append(input logic [WORD_W-1:0] msg, input logic [WORD_W-1:0] tim);
        send_cmd(OP_APPEND, msg, tim, CNT_W'($urandom_range(0, LOG_SLOTS)));
    endtask

    task automatic read_tail(input int k);
        send_cmd(OP_READ, rand_word(), rand_word(), CNT_W'(k));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_entries_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] raw);
        wait_idle();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data.capacity_in_use <= raw;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cap_now    = capacity_from_raw(raw);
        wr_slot    = 0;
        fill_count = 0;
        n_cfg++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int stall;
        int r;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_rsp_cycles--;
            end
            else if (steady)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    rsp_ch.ready <= 1'b1;
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        clog_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_entries_q.size() == 0)
            begin
                report_mismatch("unexpected transaction", 64'(rsp_ch.data), 64'd0);
            end
            else
            begin
                want = pending_entries_q.pop_front();
                if (rsp_ch.data.entry_message !== want.entry_message)
                begin
                    report_mismatch("entry_message", 64'(rsp_ch.data.entry_message),
                                    64'(want.entry_message));
                end
                if (rsp_ch.data.entry_time !== want.entry_time)
                begin
                    report_mismatch("entry_time", 64'(rsp_ch.data.entry_time),
                                    64'(want.entry_time));
                end
                if (rsp_ch.data.status !== want.status)
                begin
                    report_mismatch("status", 64'(rsp_ch.data.status), 64'(want.status));
                end
                if (rsp_ch.data.last !== want.last)
                begin
                    report_mismatch("last", 64'(rsp_ch.data.last), 64'(want.last));
                end
                if (want.status == ST_ENTRY)
                begin
                    n_entry_rsp++;
                end
                else
                begin
                    n_status_rsp++;
                end
            end
        end
    end

    task automatic test_empty_log();
        read_tail(0);
        read_tail(1);
        read_tail(LOG_SLOTS);
    endtask

    task automatic test_field_extremes();
        append('0, '1);
        append('1, '0);
        read_tail(2);
        read_tail(3);
    endtask

    task automatic test_small_capacity_wrap();
        write_capacity(CNT_W'(3));
        append(32'h0000_0011, 32'h0000_0100);
        append(32'h0000_0022, 32'h0000_0200);
        append(32'h0000_0033, 32'h0000_0300);
        append(32'h0000_0044, 32'h0000_0400);
        read_tail(3);
        read_tail(4);
        read_tail(0);
    endtask

    task automatic test_capacity_clamp();
        write_capacity(CNT_W'(0));
        append(rand_word(), rand_word());
        append(rand_word(), rand_word());
        read_tail(1);
        read_tail(2);
        write_capacity('1);
        read_tail(1);
        write_capacity(CNT_W'(LOG_SLOTS + 1));
        append(rand_word(), rand_word());
        read_tail(1);
    endtask

    task automatic test_backpressure();
        write_capacity(CNT_W'(LOG_SLOTS));
        for (int i = 0; i < LOG_SLOTS + 2; i++)
        begin
            append(rand_word(), rand_word());
        end
        hold_rsp_cycles = 80;
        read_tail(LOG_SLOTS);
        read_tail(LOG_SLOTS);
        read_tail(8);
        append(rand_word(), rand_word());
        read_tail(LOG_SLOTS);
    endtask

    task automatic random_phase(input logic [CNT_W-1:0] raw_cap, input int items);
        int r;
        int k;
        write_capacity(raw_cap);
        for (int n = 0; n < items; n++)
        begin
            r = $urandom_range(0, 99);
            if (fill_count == 0 || r < 55)
            begin
                append(rand_word(), rand_word());
            end
            else if (r < 88)
            begin
                read_tail($urandom_range(1, fill_count));
            end
            else if (r < 92)
            begin
                read_tail(0);
            end
            else if (r < 96 && cap_now < LOG_SLOTS)
            begin
                read_tail($urandom_range(cap_now + 1, LOG_SLOTS));
            end
            else if (fill_count < cap_now)
            begin
                read_tail($urandom_range(fill_count + 1, cap_now));
            end
            else
            begin
                read_tail($urandom_range(0, LOG_SLOTS));
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(CNT_W'(LOG_SLOTS), 30);
        random_phase(CNT_W'(1), 15);
        random_phase(CNT_W'(2), 20);
        steady = 1'b1;
        random_phase(CNT_W'($urandom_range(3, LOG_SLOTS)), 25);
        steady = 1'b0;
        random_phase('1, 27);
        random_phase(CNT_W'($urandom_range(1, LOG_SLOTS)), 25);
        random_phase(CNT_W'(5), 25);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.data      = '0;
        rsp_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        error_count      = 0;
        n_append         = 0;
        n_read           = 0;
        n_entry_rsp      = 0;
        n_status_rsp     = 0;
        n_cfg            = 0;
        steady           = 1'b0;
        hold_rsp_cycles  = 0;
        cap_now          = capacity_from_raw(CNT_W'(DEF_CAP));
        wr_slot          = 0;
        fill_count       = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_empty_log();
        test_field_extremes();
        test_small_capacity_wrap();
        test_capacity_clamp();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d appends, %0d tail reads, %0d capacity writes",
                 n_append, n_read, n_cfg);
        $display("checked %0d entry and %0d status transactions, %0d mismatches",
                 n_entry_rsp, n_status_rsp, error_count);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
